### src/mse_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit: shared definitions
// Operation codes, decoded control bundle, queue entry and result layout used
// by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

   // Field widths fixed by the instruction item and result layout.
   localparam int OP_W       = 4;
   localparam int REG_W      = 5;
   localparam int DATA_W     = 32;
   localparam int TGT_W      = 11;
   localparam int PC_OUT_W   = 11;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 80;

   // Operation codes carried on the request tuser.
   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_ADDI = 4'd2;
   localparam logic [OP_W-1:0] OP_SUBI = 4'd3;
   localparam logic [OP_W-1:0] OP_OR   = 4'd4;
   localparam logic [OP_W-1:0] OP_AND  = 4'd5;
   localparam logic [OP_W-1:0] OP_SLL  = 4'd6;
   localparam logic [OP_W-1:0] OP_SRL  = 4'd7;
   localparam logic [OP_W-1:0] OP_LW   = 4'd8;
   localparam logic [OP_W-1:0] OP_SW   = 4'd9;
   localparam logic [OP_W-1:0] OP_LBU  = 4'd10;
   localparam logic [OP_W-1:0] OP_SBU  = 4'd11;
   localparam logic [OP_W-1:0] OP_J    = 4'd12;
   localparam logic [OP_W-1:0] OP_BEQ  = 4'd13;
   localparam logic [OP_W-1:0] OP_BNE  = 4'd14;
   localparam logic [OP_W-1:0] OP_SLT  = 4'd15;

   // ALU function select.
   localparam int ALU_W = 3;
   localparam logic [ALU_W-1:0] ALU_ADD = 3'd0;
   localparam logic [ALU_W-1:0] ALU_SUB = 3'd1;
   localparam logic [ALU_W-1:0] ALU_OR  = 3'd2;
   localparam logic [ALU_W-1:0] ALU_AND = 3'd3;
   localparam logic [ALU_W-1:0] ALU_SLL = 3'd4;
   localparam logic [ALU_W-1:0] ALU_SRL = 3'd5;
   localparam logic [ALU_W-1:0] ALU_SLT = 3'd6;

   // Multi-cycle mode costs.
   localparam int COST_W = 3;
   localparam logic [COST_W-1:0] COST_BRANCH = 3'd3;
   localparam logic [COST_W-1:0] COST_OTHER  = 3'd4;
   localparam logic [COST_W-1:0] COST_LOAD   = 3'd5;

   localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Decoded control for one instruction.
   typedef struct packed {
      logic [ALU_W-1:0]  alu_sel;
      logic              use_imm;
      logic              wreg;
      logic              load;
      logic              store;
      logic              byte_op;
      logic              jump;
      logic              beq;
      logic              bne;
      logic [COST_W-1:0] cost;
   } mse_ctl_type;

   // Queue entry: control plus register indexes already reduced to the file size.
   typedef struct packed {
      mse_ctl_type       ctl;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  ra;
      logic [REG_W-1:0]  rb;
      logic [DATA_W-1:0] imm;
      logic [TGT_W-1:0]  target;
      logic              known;
   } mse_item_type;

   // Result beat, next_pc in the lowest bits.
   typedef struct packed {
      logic [DATA_W-1:0]   total_cycles;
      logic                address_fault;
      logic                branch_taken;
      logic [DATA_W-1:0]   written_value;
      logic                reg_written;
      logic [PC_OUT_W-1:0] next_pc;
   } mse_result_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(mse_result_type);

endpackage

`default_nettype wire

### src/mse_front.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit: front end
// Accepts instruction beats, decodes the operation into a control bundle,
// picks the two register read indexes and queues the result for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_front import mse_pkg::*; #(
   parameter int REG_COUNT = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // dest_reg[4:0], src_reg[9:5], second_reg[14:10], immediate[46:15],
   // jump_target[57:47], target_known[58], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[3:0]
   input  wire logic [OP_W-1:0]        req_tuser,
   output logic                        q_valid,
   output mse_item_type                q_item,
   input  wire logic                   q_pop
);

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int MOD_W  = REG_W + 2;

   // Register index modulo the file size; at most three subtractions are needed.
   function automatic logic [REG_W-1:0] reg_mod(input logic [REG_W-1:0] idx);
      logic [MOD_W-1:0] v;
      v = MOD_W'(idx);
      for (int i = 0; i < 4; i++) begin
         if (v >= MOD_W'(REG_COUNT)) begin
            v = v - MOD_W'(REG_COUNT);
         end
      end
      return v[REG_W-1:0];
   endfunction

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   logic [REG_W-1:0]  dest_idx;
   logic [REG_W-1:0]  src_idx;
   logic [REG_W-1:0]  second_idx;
   mse_ctl_type       ctl;
   mse_item_type      item;
   logic              push;

   mse_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Field unpacking and register index reduction.
   assign dest_idx   = reg_mod(req_tdata[4:0]);
   assign src_idx    = reg_mod(req_tdata[9:5]);
   assign second_idx = reg_mod(req_tdata[14:10]);

   // Operation decode.
   always_comb begin
      ctl      = '0;
      ctl.cost = COST_OTHER;
      unique case (req_tuser)
         OP_ADD: begin
            ctl.alu_sel = ALU_ADD;
            ctl.wreg    = 1'b1;
         end
         OP_SUB: begin
            ctl.alu_sel = ALU_SUB;
            ctl.wreg    = 1'b1;
         end
         OP_ADDI: begin
            ctl.alu_sel = ALU_ADD;
            ctl.use_imm = 1'b1;
            ctl.wreg    = 1'b1;
         end
         OP_SUBI: begin
            ctl.alu_sel = ALU_SUB;
            ctl.use_imm = 1'b1;
            ctl.wreg    = 1'b1;
         end
         OP_OR: begin
            ctl.alu_sel = ALU_OR;
            ctl.wreg    = 1'b1;
         end
         OP_AND: begin
            ctl.alu_sel = ALU_AND;
            ctl.wreg    = 1'b1;
         end
         OP_SLL: begin
            ctl.alu_sel = ALU_SLL;
            ctl.wreg    = 1'b1;
         end
         OP_SRL: begin
            ctl.alu_sel = ALU_SRL;
            ctl.wreg    = 1'b1;
         end
         OP_LW: begin
            ctl.load = 1'b1;
            ctl.wreg = 1'b1;
            ctl.cost = COST_LOAD;
         end
         OP_SW: begin
            ctl.store = 1'b1;
         end
         OP_LBU: begin
            ctl.load    = 1'b1;
            ctl.byte_op = 1'b1;
            ctl.wreg    = 1'b1;
            ctl.cost    = COST_LOAD;
         end
         OP_SBU: begin
            ctl.store   = 1'b1;
            ctl.byte_op = 1'b1;
         end
         OP_J: begin
            ctl.jump = 1'b1;
            ctl.cost = COST_BRANCH;
         end
         OP_BEQ: begin
            ctl.beq  = 1'b1;
            ctl.cost = COST_BRANCH;
         end
         OP_BNE: begin
            ctl.bne  = 1'b1;
            ctl.cost = COST_BRANCH;
         end
         OP_SLT: begin
            ctl.alu_sel = ALU_SLT;
            ctl.wreg    = 1'b1;
         end
      endcase
   end

   // Read port A carries the store data for stores, port B the first compare
   // register for branches; otherwise they read the two sources.
   always_comb begin
      item.ctl    = ctl;
      item.rd     = dest_idx;
      item.ra     = ctl.store ? dest_idx : src_idx;
      item.rb     = (ctl.beq || ctl.bne) ? dest_idx : second_idx;
      item.imm    = req_tdata[46:15];
      item.target = req_tdata[57:47];
      item.known  = req_tdata[58];
   end

   // Queue control.
   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

### src/mse_back.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit: back end
// Reads the register file, executes the instruction, accesses the data store,
// updates program counter and cycle count and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_back import mse_pkg::*; #(
   parameter int REG_COUNT  = 32,
   parameter int MEM_WORDS  = 1024,
   parameter int INST_BYTES = 2048
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire mse_item_type q_item,
   output logic          q_pop,
   input  wire logic     csr_wr_en,
   input  wire logic     csr_wr_data,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   output mse_result_type rsp_result
);

   localparam int RW = $clog2(REG_COUNT);
   localparam int AW = $clog2(MEM_WORDS);
   localparam int PW = $clog2(INST_BYTES);
   localparam int XW = ((PW > TGT_W) ? PW : TGT_W) + 1;
   localparam int SW = DATA_W + 1;

   localparam logic [1:0] ST_READ = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   // Jump target modulo the instruction space; at most seven subtractions.
   function automatic logic [XW-1:0] tgt_mod(input logic [TGT_W-1:0] t);
      logic [XW-1:0] v;
      v = XW'(t);
      for (int i = 0; i < 8; i++) begin
         if (v >= XW'(INST_BYTES)) begin
            v = v - XW'(INST_BYTES);
         end
      end
      return v;
   endfunction

   logic [1:0]          state_ff, state_in;
   mse_item_type        item_ff;
   logic [DATA_W-1:0]   opa_ff, opb_ff;
   logic                opa_vld_ff, opb_vld_ff;
   logic [DATA_W-1:0]   rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;
   logic [DATA_W-1:0]   dm_mem [MEM_WORDS];
   logic [DATA_W-1:0]   dm_rdata_ff;
   logic                fault_ff, fault_in;
   logic                mode_ff, mode_in;
   logic [PW-1:0]       pc_ff, pc_in;
   logic [DATA_W-1:0]   cyc_ff, cyc_in;
   logic                out_valid_ff, out_valid_in;
   mse_result_type      out_ff, out_in;

   logic [RW-1:0]       ra_idx, rb_idx, rd_idx;
   logic [DATA_W-1:0]   op_a, op_b, src2, alu_val, store_val, load_val, wb_val;
   logic [SW-1:0]       mem_sum;
   logic                in_range;
   logic [AW-1:0]       dm_addr;
   logic                eq, taken, fault, is_branch;
   logic                out_can, commit, exec_load, dm_we, dm_re, rf_we;
   logic [PW:0]         pc_inc, pc_adv;
   logic [PW-1:0]       pc_new;
   logic [XW-1:0]       pc_new_x;
   logic [DATA_W-1:0]   cyc_new;

   assign ra_idx = RW'(q_item.ra);
   assign rb_idx = RW'(q_item.rb);
   assign rd_idx = RW'(item_ff.rd);

   // Register file reads, registered; an entry never written reads as zero.
   assign q_pop = (state_ff == ST_READ) && q_valid;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff    <= q_item;
         opa_ff     <= rf_mem[ra_idx];
         opb_ff     <= rf_mem[rb_idx];
         opa_vld_ff <= rf_valid_ff[ra_idx];
         opb_vld_ff <= rf_valid_ff[rb_idx];
      end
      if (rf_we) begin
         rf_mem[rd_idx] <= wb_val;
      end
   end

   assign op_a = opa_vld_ff ? opa_ff : '0;
   assign op_b = opb_vld_ff ? opb_ff : '0;

   // ALU.
   assign src2 = item_ff.ctl.use_imm ? item_ff.imm : op_b;

   always_comb begin
      unique case (item_ff.ctl.alu_sel)
         ALU_ADD: alu_val = op_a + src2;
         ALU_SUB: alu_val = op_a - src2;
         ALU_OR:  alu_val = op_a | src2;
         ALU_AND: alu_val = op_a & src2;
         ALU_SLL: alu_val = op_a << item_ff.imm[4:0];
         ALU_SRL: alu_val = op_a >> item_ff.imm[4:0];
         ALU_SLT: alu_val = ($signed(op_a) < $signed(op_b)) ? DATA_W'(1) : '0;
         default: alu_val = '0;
      endcase
   end

   // Word address from the signed base plus the signed offset.
   assign mem_sum  = {op_b[DATA_W-1], op_b} + {item_ff.imm[DATA_W-1], item_ff.imm};
   assign in_range = !mem_sum[SW-1] && (mem_sum < SW'(MEM_WORDS));
   assign dm_addr  = mem_sum[AW-1:0];

   assign store_val = item_ff.ctl.byte_op ? (op_a & BYTE_MASK) : op_a;
   assign load_val  = fault_ff ? '0 :
                      (item_ff.ctl.byte_op ? (dm_rdata_ff & BYTE_MASK) : dm_rdata_ff);

   // Branch resolution.
   assign eq        = (op_b == op_a);
   assign is_branch = item_ff.ctl.jump || item_ff.ctl.beq || item_ff.ctl.bne;
   assign taken     = item_ff.known && (item_ff.ctl.jump || (item_ff.ctl.beq && eq) ||
                                        (item_ff.ctl.bne && !eq));

   // Write-back value and fault flag.
   always_comb begin
      if (state_ff == ST_LOAD) begin
         wb_val = load_val;
         fault  = fault_ff;
      end else if (item_ff.ctl.store) begin
         wb_val = in_range ? store_val : '0;
         fault  = !in_range;
      end else if (is_branch) begin
         wb_val = '0;
         fault  = 1'b0;
      end else begin
         wb_val = alu_val;
         fault  = 1'b0;
      end
   end

   // Commit: all architectural state updates and the result beat.
   assign out_can   = !out_valid_ff || rsp_tready;
   assign exec_load = (state_ff == ST_EXEC) && item_ff.ctl.load;
   assign commit    = out_can && (((state_ff == ST_EXEC) && !item_ff.ctl.load) ||
                                  (state_ff == ST_LOAD));
   assign rf_we     = commit && item_ff.ctl.wreg;
   assign dm_we     = commit && (state_ff == ST_EXEC) && item_ff.ctl.store && in_range;
   assign dm_re     = exec_load && in_range;
   assign fault_in  = !in_range;

   // Data store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_addr] <= store_val;
      end
      if (dm_re) begin
         dm_rdata_ff <= dm_mem[dm_addr];
      end
      if (exec_load) begin
         fault_ff <= fault_in;
      end
   end

   // Program counter and cycle count.
   assign pc_inc   = {1'b0, pc_ff} + (PW+1)'(4);
   assign pc_adv   = (pc_inc >= (PW+1)'(INST_BYTES)) ? pc_inc - (PW+1)'(INST_BYTES) : pc_inc;
   assign pc_new   = taken ? PW'(tgt_mod(item_ff.target)) : pc_adv[PW-1:0];
   assign pc_new_x = XW'(pc_new);
   assign cyc_new  = cyc_ff + (mode_ff ? DATA_W'(item_ff.ctl.cost) : DATA_W'(1));

   always_comb begin
      out_in.next_pc       = pc_new_x[PC_OUT_W-1:0];
      out_in.reg_written   = item_ff.ctl.wreg;
      out_in.written_value = wb_val;
      out_in.branch_taken  = taken;
      out_in.address_fault = fault;
      out_in.total_cycles  = cyc_new;
   end

   // Next values of control state.
   always_comb begin
      pc_in        = commit ? pc_new : pc_ff;
      cyc_in       = commit ? cyc_new : cyc_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      rf_valid_in  = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[rd_idx] = 1'b1;
      end
      out_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      state_in     = state_ff;
      unique case (state_ff)
         ST_READ: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.ctl.load) begin
               state_in = ST_LOAD;
            end else if (commit) begin
               state_in = ST_READ;
            end
         end
         ST_LOAD: begin
            if (commit) begin
               state_in = ST_READ;
            end
         end
         default: state_in = ST_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         rf_valid_ff  <= '0;
         mode_ff      <= 1'b0;
         pc_ff        <= '0;
         cyc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rf_valid_ff  <= rf_valid_in;
         mode_ff      <= mode_in;
         pc_ff        <= pc_in;
         cyc_ff       <= cyc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (commit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   // A load waits in its last step while the result register stays blocked.
   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && out_valid_ff && !rsp_tready) |=> (state_ff == ST_LOAD))
      else $error("load step left while the result register was blocked");

   // The load step is only reached from execute.
   a_load_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_LOAD))
      else $error("load step entered without execute");

   // A new result beat never appears straight after a register read step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) != ST_READ))
      else $error("result produced from the read step");

   // A popped instruction always goes to execute.
   a_pop_exec: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_EXEC))
      else $error("popped instruction did not enter execute");

   // The program counter stays within the instruction space.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < INST_BYTES)
      else $error("program counter outside the instruction space");

endmodule

`default_nettype wire

### src/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// Executes decoded instructions of a sixteen-operation subset against its own
// register file, data store, program counter and cycle count.
// ----------------------------------------------------------------------------
// Usage:
//   One instruction is accepted per req beat (req_tuser carries the operation,
//   req_tdata the operands) and yields exactly one rsp beat, in order.
//   csr_wr_en/csr_wr_data select the cycle cost mode; the user must write them
//   only while no instruction is in flight, as the block does not enforce it.
//   Flow: an accepted beat enters a two-entry queue; the back end reads the
//   register file in its read step and executes and commits in its execute
//   step; loads add a load step for the registered data store read, and the
//   result register is loaded at commit. A new instruction is taken only
//   after the previous one has committed, following the read, execute and,
//   for loads, load step sequence of the back end.
//   Reset: program counter, cycle count and mode go to zero, the register
//   file reads as zero through per-entry valid bits, the queue and result
//   register empty. The data store has no clearing pass and must be written
//   before it is read.
//   Stall: a held result stays on rsp_tdata; the back end waits before
//   committing, the queue fills and req_tready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_execute_unit import mse_pkg::*; #(
   parameter int REG_COUNT  = 32,
   parameter int MEM_WORDS  = 1024,
   parameter int INST_BYTES = 2048
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // dest_reg[4:0], src_reg[9:5], second_reg[14:10], immediate[46:15],
   // jump_target[57:47], target_known[58], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[3:0]
   input  wire logic [OP_W-1:0]        req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // next_pc[10:0], reg_written[11], written_value[43:12], branch_taken[44],
   // address_fault[45], total_cycles[77:46], zero fill above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data
);

   logic           q_valid;
   logic           q_pop;
   mse_item_type   q_item;
   mse_result_type rsp_result;

   // Front end: decode and queue.
   mse_front #(
      .REG_COUNT (REG_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: execute and commit.
   mse_back #(
      .REG_COUNT  (REG_COUNT),
      .MEM_WORDS  (MEM_WORDS),
      .INST_BYTES (INST_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (rsp_result)
   );

   // Result beat packing.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_result};

endmodule

`default_nettype wire
